FILE: design/tdjm_pkg.sv
// Shared types and constants for the task deadline and jitter monitor.
package tdjm_pkg;

    localparam int STAMP_W     = 32;
    localparam int TASK_W      = 2;
    localparam int NUM_SLOTS   = 4;
    localparam int ALU_W       = STAMP_W + 1;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 2 * STAMP_W;
    localparam int OUT_BITS    = 7 * STAMP_W + 2;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [STAMP_W-1:0] TOL_US = 32'd1000;

    localparam logic [STAMP_W-1:0] PERIOD_RESET [NUM_SLOTS] =
        '{32'd50000, 32'd50000, 32'd50000, 32'd100000};
    localparam logic [STAMP_W-1:0] DEADLINE_RESET [NUM_SLOTS] =
        '{32'd50000, 32'd50000, 32'd50000, 32'd100000};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PER,
        ST_MAXP,
        ST_TOL,
        ST_LATE,
        ST_MAXE,
        ST_MISS,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } alu_rsp_t;

    typedef struct packed {
        logic [STAMP_W-1:0] cycle_total;
        logic [STAMP_W-1:0] late_total;
        logic [STAMP_W-1:0] missed_total;
        logic [STAMP_W-1:0] max_exec_out;
        logic [STAMP_W-1:0] max_period_out;
        logic               deadline_missed;
        logic               period_late;
        logic               period_valid;
        logic [STAMP_W-1:0] measured_period;
        logic [STAMP_W-1:0] exec_time;
    } result_t;

endpackage

FILE: design/tdjm_alu.sv
// Shared 33-bit add/subtract unit; carry set on subtract means a >= b.
module tdjm_alu (
    input  tdjm_pkg::alu_req_t req,
    output tdjm_pkg::alu_rsp_t rsp
);

    logic [tdjm_pkg::ALU_W-1:0] b_op;
    logic [tdjm_pkg::ALU_W:0]   total;

    assign b_op  = req.sub ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_op} + (tdjm_pkg::ALU_W + 1)'(req.sub);

    assign rsp.sum   = total[tdjm_pkg::ALU_W-1:0];
    assign rsp.carry = total[tdjm_pkg::ALU_W];

endmodule

FILE: design/tdjm_cfg.sv
// Configuration register file: per-task nominal period and deadline, APB access.
module tdjm_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tdjm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [tdjm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [tdjm_pkg::CFG_DATA_W-1:0]     prdata,
    input  logic [tdjm_pkg::TASK_W-1:0]         sel,
    output logic [tdjm_pkg::STAMP_W-1:0]        period_sel,
    output logic [tdjm_pkg::STAMP_W-1:0]        deadline_sel
);

    logic [tdjm_pkg::STAMP_W-1:0] period_reg   [tdjm_pkg::NUM_SLOTS];
    logic [tdjm_pkg::STAMP_W-1:0] deadline_reg [tdjm_pkg::NUM_SLOTS];
    logic [2:0]                   reg_idx;
    logic [1:0]                   slot;
    logic                         wr_en;

    assign reg_idx = paddr[4:2];
    assign slot    = reg_idx[1:0];
    assign wr_en   = psel && penable && pwrite;

    // Upper half of the register map holds the deadlines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= tdjm_pkg::PERIOD_RESET;
            deadline_reg <= tdjm_pkg::DEADLINE_RESET;
        end
        else if (wr_en)
        begin
            if (reg_idx[2])
                deadline_reg[slot] <= pwdata;
            else
                period_reg[slot] <= pwdata;
        end
    end

    assign prdata       = reg_idx[2] ? deadline_reg[slot] : period_reg[slot];
    assign period_sel   = period_reg[sel];
    assign deadline_sel = deadline_reg[sel];

endmodule

FILE: design/tdjm_ctrl.sv
// Sequencer, per-task record store and result register of the monitor.
module tdjm_ctrl #(
    parameter int unsigned NUM_TASKS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tdjm_pkg::TASK_W-1:0]     in_task,
    input  logic [tdjm_pkg::STAMP_W-1:0]    in_start,
    input  logic [tdjm_pkg::STAMP_W-1:0]    in_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tdjm_pkg::result_t               out_result,
    output logic [tdjm_pkg::TASK_W-1:0]     cfg_sel,
    input  logic [tdjm_pkg::STAMP_W-1:0]    period_sel,
    input  logic [tdjm_pkg::STAMP_W-1:0]    deadline_sel,
    output tdjm_pkg::alu_req_t              alu_req,
    input  tdjm_pkg::alu_rsp_t              alu_rsp
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int SW    = tdjm_pkg::STAMP_W;
    localparam int AW    = tdjm_pkg::ALU_W;

    tdjm_pkg::state_t state_reg, state_next;

    // Per-task records
    logic [SW-1:0] last_start_reg [NUM_TASKS];
    logic [SW-1:0] max_period_reg [NUM_TASKS];
    logic [SW-1:0] max_exec_reg   [NUM_TASKS];
    logic [SW-1:0] missed_cnt_reg [NUM_TASKS];
    logic [SW-1:0] late_cnt_reg   [NUM_TASKS];
    logic [SW-1:0] cycle_cnt_reg  [NUM_TASKS];

    // Working copy of the item under evaluation
    logic [tdjm_pkg::TASK_W-1:0] task_reg;
    logic [SW-1:0]               start_reg;
    logic [SW-1:0]               end_reg;
    logic [SW-1:0]               last_reg;
    logic [SW-1:0]               exec_reg;
    logic [SW-1:0]               per_reg;
    logic [AW-1:0]               tol_reg;
    logic [SW-1:0]               maxp_reg;
    logic [SW-1:0]               maxe_reg;
    logic [SW-1:0]               miss_cnt_reg;
    logic [SW-1:0]               late_wrk_reg;
    logic [SW-1:0]               cyc_cnt_reg;
    logic                        valid_reg;
    logic                        late_reg;
    logic                        missed_reg;

    tdjm_pkg::result_t result_reg;
    logic              out_valid_reg;

    logic             in_fire;
    logic             task_ok;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] wr_idx;
    logic             take_out;
    logic [SW-1:0]    miss_tot;
    logic [SW-1:0]    late_tot;
    logic [SW-1:0]    cyc_tot;

    assign in_ready = (state_reg == tdjm_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign task_ok  = 32'(in_task) < NUM_TASKS;
    assign in_idx   = in_task[IDX_W-1:0];
    assign wr_idx   = task_reg[IDX_W-1:0];
    assign take_out = (state_reg == tdjm_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign cfg_sel  = task_reg;

    assign miss_tot = miss_cnt_reg + SW'(missed_reg);
    assign late_tot = late_wrk_reg + SW'(late_reg);
    assign cyc_tot  = cyc_cnt_reg + SW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tdjm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and operand selection for the shared unit
    always_comb
    begin
        state_next  = state_reg;
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b1;
        case (state_reg)
            tdjm_pkg::ST_IDLE:
            begin
                if (in_fire && task_ok)
                    state_next = tdjm_pkg::ST_EXEC;
            end
            tdjm_pkg::ST_EXEC:
            begin
                alu_req.a  = AW'(end_reg);
                alu_req.b  = AW'(start_reg);
                state_next = valid_reg ? tdjm_pkg::ST_PER : tdjm_pkg::ST_MAXE;
            end
            tdjm_pkg::ST_PER:
            begin
                alu_req.a  = AW'(start_reg);
                alu_req.b  = AW'(last_reg);
                state_next = tdjm_pkg::ST_MAXP;
            end
            tdjm_pkg::ST_MAXP:
            begin
                alu_req.a  = AW'(maxp_reg);
                alu_req.b  = AW'(per_reg);
                state_next = tdjm_pkg::ST_TOL;
            end
            tdjm_pkg::ST_TOL:
            begin
                alu_req.a   = AW'(period_sel);
                alu_req.b   = AW'(tdjm_pkg::TOL_US);
                alu_req.sub = 1'b0;
                state_next  = tdjm_pkg::ST_LATE;
            end
            tdjm_pkg::ST_LATE:
            begin
                alu_req.a  = tol_reg;
                alu_req.b  = AW'(per_reg);
                state_next = tdjm_pkg::ST_MAXE;
            end
            tdjm_pkg::ST_MAXE:
            begin
                alu_req.a  = AW'(maxe_reg);
                alu_req.b  = AW'(exec_reg);
                state_next = tdjm_pkg::ST_MISS;
            end
            tdjm_pkg::ST_MISS:
            begin
                alu_req.a  = AW'(deadline_sel);
                alu_req.b  = AW'(exec_reg);
                state_next = tdjm_pkg::ST_DONE;
            end
            tdjm_pkg::ST_DONE:
            begin
                if (take_out)
                    state_next = tdjm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tdjm_pkg::ST_IDLE;
            end
        endcase
    end

    // Working registers: load on accept, then capture one unit result per step
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tdjm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    task_reg     <= in_task;
                    start_reg    <= in_start;
                    end_reg      <= in_end;
                    last_reg     <= last_start_reg[in_idx];
                    valid_reg    <= (last_start_reg[in_idx] != '0);
                    maxp_reg     <= max_period_reg[in_idx];
                    maxe_reg     <= max_exec_reg[in_idx];
                    miss_cnt_reg <= missed_cnt_reg[in_idx];
                    late_wrk_reg <= late_cnt_reg[in_idx];
                    cyc_cnt_reg  <= cycle_cnt_reg[in_idx];
                    per_reg      <= '0;
                    late_reg     <= 1'b0;
                end
            end
            tdjm_pkg::ST_EXEC: exec_reg <= alu_rsp.sum[SW-1:0];
            tdjm_pkg::ST_PER:  per_reg  <= alu_rsp.sum[SW-1:0];
            tdjm_pkg::ST_MAXP:
            begin
                if (!alu_rsp.carry)
                    maxp_reg <= per_reg;
            end
            tdjm_pkg::ST_TOL:  tol_reg  <= alu_rsp.sum;
            tdjm_pkg::ST_LATE: late_reg <= !alu_rsp.carry;
            tdjm_pkg::ST_MAXE:
            begin
                if (!alu_rsp.carry)
                    maxe_reg <= exec_reg;
            end
            tdjm_pkg::ST_MISS: missed_reg <= !alu_rsp.carry;
            default:
            begin
            end
        endcase
    end

    // Record store: write back the updated record when the result is released
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                last_start_reg[i] <= '0;
                max_period_reg[i] <= '0;
                max_exec_reg[i]   <= '0;
                missed_cnt_reg[i] <= '0;
                late_cnt_reg[i]   <= '0;
                cycle_cnt_reg[i]  <= '0;
            end
        end
        else if (take_out)
        begin
            last_start_reg[wr_idx] <= start_reg;
            max_period_reg[wr_idx] <= maxp_reg;
            max_exec_reg[wr_idx]   <= maxe_reg;
            missed_cnt_reg[wr_idx] <= miss_tot;
            late_cnt_reg[wr_idx]   <= late_tot;
            cycle_cnt_reg[wr_idx]  <= cyc_tot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            result_reg.exec_time       <= exec_reg;
            result_reg.measured_period <= per_reg;
            result_reg.period_valid    <= valid_reg;
            result_reg.period_late     <= late_reg;
            result_reg.deadline_missed <= missed_reg;
            result_reg.max_period_out  <= maxp_reg;
            result_reg.max_exec_out    <= maxe_reg;
            result_reg.missed_total    <= miss_tot;
            result_reg.late_total      <= late_tot;
            result_reg.cycle_total     <= cyc_tot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    a_release_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take_out |=> out_valid_reg)
        else $error("released result not presented");

    a_taken_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ready && !take_out |=> !out_valid_reg)
        else $error("result presented twice");

    a_late_needs_period: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!result_reg.period_late || result_reg.period_valid))
        else $error("late flag without a measured period");

    a_no_period_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.period_valid |-> result_reg.measured_period == '0)
        else $error("period nonzero while not measured");

    a_drop_unknown_task: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !task_ok |=> state_reg == tdjm_pkg::ST_IDLE)
        else $error("report of unmonitored task started evaluation");

endmodule

FILE: design/task_deadline_jitter_monitor.sv
// Top level of the per-task deadline and period jitter monitor.
//
//  channel   | direction | handshake                     | contents
//  ----------+-----------+-------------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | activation report per item
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | updated task record per item
//  apb       | in/out    | psel, penable, pready         | period and deadline registers
//
//  A new item is accepted only in the idle state, after the last result is released; the
//  period steps run only when the task has a stored start. The single 33-bit add/subtract
//  unit serves the execution time, period, tolerance sum and four compares one after another.
//  Reset loads the nominal periods and deadlines and clears all task records at once;
//  there is no clearing pass. A result waits in the output register while the next item
//  is taken; evaluation holds in its last step only if that register is still full.
//  Reports for task numbers at or above NUM_TASKS are taken and dropped without a result.
module task_deadline_jitter_monitor #(
    parameter int unsigned NUM_TASKS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // activation report
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] start_stamp, [63:32] end_stamp
    input  logic [tdjm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] task_index
    input  logic [tdjm_pkg::TASK_W-1:0]          s_axis_tuser,
    // updated record
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] exec_time, [63:32] measured_period, [64] period_late,
    // [65] deadline_missed, [97:66] max_period_out, [129:98] max_exec_out,
    // [161:130] missed_total, [193:162] late_total, [225:194] cycle_total,
    // [231:226] zero
    output logic [tdjm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] period_valid
    output logic                                 m_axis_tuser,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tdjm_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [tdjm_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [tdjm_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    tdjm_pkg::alu_req_t            alu_req;
    tdjm_pkg::alu_rsp_t            alu_rsp;
    tdjm_pkg::result_t             result;
    logic [tdjm_pkg::TASK_W-1:0]   cfg_sel;
    logic [tdjm_pkg::STAMP_W-1:0]  period_sel;
    logic [tdjm_pkg::STAMP_W-1:0]  deadline_sel;

    // Register accesses complete without wait states
    assign pready = 1'b1;

    tdjm_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .sel          (cfg_sel),
        .period_sel   (period_sel),
        .deadline_sel (deadline_sel)
    );

    tdjm_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    tdjm_ctrl #(
        .NUM_TASKS (NUM_TASKS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_task      (s_axis_tuser),
        .in_start     (s_axis_tdata[tdjm_pkg::STAMP_W-1:0]),
        .in_end       (s_axis_tdata[2*tdjm_pkg::STAMP_W-1:tdjm_pkg::STAMP_W]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_result   (result),
        .cfg_sel      (cfg_sel),
        .period_sel   (period_sel),
        .deadline_sel (deadline_sel),
        .alu_req      (alu_req),
        .alu_rsp      (alu_rsp)
    );

    // Pack the record, first field in the low bits; period_valid goes out on tuser
    assign m_axis_tdata = {
        {(tdjm_pkg::OUT_TDATA_W - tdjm_pkg::OUT_BITS){1'b0}},
        result.cycle_total,
        result.late_total,
        result.missed_total,
        result.max_exec_out,
        result.max_period_out,
        result.deadline_missed,
        result.period_late,
        result.measured_period,
        result.exec_time
    };
    assign m_axis_tuser = result.period_valid;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the per-task deadline and period jitter monitor.
`timescale 1ns / 100ps

module testbench;

    import tdjm_pkg::*;

    // Four monitored tasks, as in the standard build of the block.
    localparam int TASKS = 4;

    // Register indexes on the configuration port; byte address is 4 * index.
    localparam int REG_PERIOD0   = 0;
    localparam int REG_DEADLINE0 = 4;
    localparam int NUM_REGS      = 8;

    // Random items per phase and number of configuration phases after reset.
    localparam int PHASE_ITEMS = 190;
    localparam int NUM_PHASES  = 5;

    // Run ceiling in clock cycles, far above the slowest legal run.
    localparam int CYCLE_LIMIT = 500000;

    // Cycles to let pass after the last result before touching registers or ending.
    localparam int SETTLE_CYCLES = 12;

    // One activation report as the testbench sees it.
    typedef struct {
        logic [TASK_W-1:0]  task_id;
        logic [STAMP_W-1:0] start_us;
        logic [STAMP_W-1:0] end_us;
    } report_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [TASK_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr         = '0;
    logic [CFG_DATA_W-1:0]  pwdata        = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    // Reports waiting to be driven, and records the block still owes us.
    report_t pending_reports[$];
    result_t expected_records[$];

    // Mirror of the configuration registers.
    logic [STAMP_W-1:0] cfg_period   [TASKS];
    logic [STAMP_W-1:0] cfg_deadline [TASKS];

    // Mirror of the per-task records kept by the block.
    logic [STAMP_W-1:0] prev_start   [TASKS];
    logic [STAMP_W-1:0] peak_period  [TASKS];
    logic [STAMP_W-1:0] peak_exec    [TASKS];
    logic [STAMP_W-1:0] miss_tally   [TASKS];
    logic [STAMP_W-1:0] late_tally   [TASKS];
    logic [STAMP_W-1:0] activations  [TASKS];

    // Stimulus generator's own notion of each task's schedule.
    logic [STAMP_W-1:0] gen_start    [TASKS];

    int  error_count   = 0;
    int  tb_cycles     = 0;
    int  send_gap      = 0;
    int  ready_gap     = 0;
    bit  idle_on       = 1'b1;
    bit  report_fired  = 1'b0;

    task_deadline_jitter_monitor #(
        .NUM_TASKS(TASKS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] start_stamp, [63:32] end_stamp
        .s_axis_tuser  (s_axis_tuser),   // [1:0] task_index
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // exec_time, measured_period, period_late,
                                         // deadline_missed, max_period_out, max_exec_out,
                                         // missed_total, late_total, cycle_total, zero pad
        .m_axis_tuser  (m_axis_tuser),   // [0] period_valid
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Count one failure and print it on a single line.
    task automatic log_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            log_error($sformatf("%s got 0x%08h want 0x%08h", name, got, want));
    endtask

    // Work out the record the block must return for one report, and advance
    // the mirrored per-task state the same way the block does.
    task automatic predict_record(input report_t r);
        result_t            rec;
        logic [STAMP_W-1:0] exec_us;
        logic [STAMP_W-1:0] per_us;
        logic [ALU_W-1:0]   late_bound;
        int                 t;
        t = r.task_id;
        // Reports for tasks the block does not monitor vanish without a trace.
        if (t >= TASKS)
            return;
        rec     = '0;
        exec_us = r.end_us - r.start_us;
        rec.exec_time = exec_us;
        // A stored start of zero means no earlier activation, so no period.
        if (prev_start[t] != '0)
        begin
            per_us              = r.start_us - prev_start[t];
            rec.period_valid    = 1'b1;
            rec.measured_period = per_us;
            if (per_us > peak_period[t])
                peak_period[t] = per_us;
            // Nominal period plus tolerance, one bit wider so it never wraps.
            late_bound = {1'b0, cfg_period[t]} + {1'b0, TOL_US};
            if ({1'b0, per_us} > late_bound)
            begin
                rec.period_late = 1'b1;
                late_tally[t]   = late_tally[t] + 1;
            end
        end
        prev_start[t] = r.start_us;
        if (exec_us > peak_exec[t])
            peak_exec[t] = exec_us;
        if (exec_us > cfg_deadline[t])
        begin
            rec.deadline_missed = 1'b1;
            miss_tally[t]       = miss_tally[t] + 1;
        end
        activations[t]     = activations[t] + 1;
        rec.max_period_out = peak_period[t];
        rec.max_exec_out   = peak_exec[t];
        rec.missed_total   = miss_tally[t];
        rec.late_total     = late_tally[t];
        rec.cycle_total    = activations[t];
        expected_records.push_back(rec);
    endtask

    // Acceptance side of the input stream: take the head report and predict it.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_record(pending_reports.pop_front());
            report_fired = 1'b1;
        end
    end

    // Input driver: hold an unaccepted item, otherwise idle in bursts or
    // present the next pending report.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(s_axis_tvalid && !report_fired))
            begin
                report_fired = 1'b0;
                if (send_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 10);
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reports.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {pending_reports[0].end_us, pending_reports[0].start_us};
                    s_axis_tuser  <= pending_reports[0].task_id;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output ready: stall in random bursts while idling is on.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_gap > 0)
            begin
                ready_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                ready_gap = $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Output monitor: unpack each accepted record and check it against the
    // oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_records.size() == 0)
                log_error("record returned with none expected");
            else
            begin
                want = expected_records.pop_front();
                compare_field("exec_time",       m_axis_tdata[31:0],    want.exec_time);
                compare_field("measured_period", m_axis_tdata[63:32],   want.measured_period);
                compare_field("period_late",     32'(m_axis_tdata[64]),
                              32'(want.period_late));
                compare_field("deadline_missed", 32'(m_axis_tdata[65]),
                              32'(want.deadline_missed));
                compare_field("max_period_out",  m_axis_tdata[97:66],   want.max_period_out);
                compare_field("max_exec_out",    m_axis_tdata[129:98],  want.max_exec_out);
                compare_field("missed_total",    m_axis_tdata[161:130], want.missed_total);
                compare_field("late_total",      m_axis_tdata[193:162], want.late_total);
                compare_field("cycle_total",     m_axis_tdata[225:194], want.cycle_total);
                compare_field("tdata padding",
                              32'(m_axis_tdata[OUT_TDATA_W-1:OUT_BITS]), 32'd0);
                compare_field("period_valid",    32'(m_axis_tuser),
                              32'(want.period_valid));
            end
        end
    end

    // Hard ceiling on the run length.
    always @(posedge clk)
    begin
        tb_cycles++;
        if (tb_cycles > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic reg_write(input int idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx < REG_DEADLINE0)
            cfg_period[idx - REG_PERIOD0] = value;
        else
            cfg_deadline[idx - REG_DEADLINE0] = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read every register back and compare with the mirror.
    task automatic check_registers();
        logic [31:0] want;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= CFG_ADDR_W'(i * 4);
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            want = (i < REG_DEADLINE0) ? cfg_period[i - REG_PERIOD0]
                                       : cfg_deadline[i - REG_DEADLINE0];
            compare_field($sformatf("register %0d readback", i), prdata, want);
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Load one configuration setting; the first phases hit the extremes.
    task automatic apply_setting(input int phase);
        logic [31:0] per_v [TASKS];
        logic [31:0] dl_v  [TASKS];
        for (int t = 0; t < TASKS; t++)
        begin
            per_v[t] = $urandom_range(100, 200000);
            dl_v[t]  = $urandom_range(50, 150000);
        end
        case (phase)
            1:
            begin
                per_v = '{32'd0, 32'd4294966295, 32'd1, 32'd1000};
                dl_v  = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd50000};
            end
            2:
            begin
                per_v[0] = 32'd4294966295;
                per_v[1] = 32'd0;
                dl_v[0]  = 32'hFFFF_FFFF;
                dl_v[1]  = 32'd0;
            end
            default: ;
        endcase
        for (int t = 0; t < TASKS; t++)
        begin
            reg_write(REG_PERIOD0 + t, per_v[t]);
            reg_write(REG_DEADLINE0 + t, dl_v[t]);
        end
        check_registers();
    endtask

    task automatic add_report(input int t, input logic [31:0] s, input logic [31:0] e);
        report_t r;
        r.task_id  = TASK_W'(t);
        r.start_us = s;
        r.end_us   = e;
        pending_reports.push_back(r);
    endtask

    // Random report: mostly a plausible schedule around the configured period
    // and deadline, sometimes pure noise, now and then a zero start.
    task automatic add_random_report();
        int          t;
        int          pick;
        logic [31:0] s;
        logic [31:0] e;
        t    = $urandom_range(0, TASKS - 1);
        pick = $urandom_range(0, 19);
        if (pick < 4)
        begin
            s = $urandom;
            e = $urandom;
        end
        else if (pick == 4)
        begin
            s = '0;
            e = $urandom_range(0, 5000);
        end
        else
        begin
            s = gen_start[t] + cfg_period[t] + TOL_US + $urandom_range(0, 4000) - 2000;
            if (pick < 15)
                e = s + cfg_deadline[t] + $urandom_range(0, 400) - 200;
            else
                e = s + $urandom_range(0, 3000);
        end
        gen_start[t] = s;
        add_report(t, s, e);
    endtask

    // Wait until every report is taken and every record is back, then let
    // the block settle.
    task automatic drain();
        while (pending_reports.size() != 0 || expected_records.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        for (int t = 0; t < TASKS; t++)
        begin
            cfg_period[t]   = PERIOD_RESET[t];
            cfg_deadline[t] = DEADLINE_RESET[t];
            prev_start[t]   = '0;
            peak_period[t]  = '0;
            peak_exec[t]    = '0;
            miss_tally[t]   = '0;
            late_tally[t]   = '0;
            activations[t]  = '0;
            gen_start[t]    = '0;
        end

        // Hold reset, then drop it away from the rising edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values of the registers.
        check_registers();

        // Directed reports under the reset setting.
        // Zero start: stored, and the next activation measures no period.
        add_report(0, 32'd0, 32'd0);
        // Execution time wraps below zero.
        add_report(0, 32'd100, 32'd50);
        // Period one above nominal plus tolerance: late.
        add_report(0, 32'd51101, 32'd51101);
        // Period exactly at nominal plus tolerance: not late.
        add_report(0, 32'd102101, 32'd152101);
        // Stamps at the top of the range, execution wraps to one.
        add_report(1, 32'hFFFF_FFFF, 32'h0000_0000);
        // Period wraps past zero; execution exactly at the deadline.
        add_report(1, 32'd5, 32'd50005);
        // Execution one over the deadline.
        add_report(1, 32'd60000, 32'd110001);
        add_report(2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Zero start after a real one: period measured, then cleared history.
        add_report(2, 32'd0, 32'hFFFF_FFFF);
        add_report(2, 32'd1234, 32'd1235);
        add_report(3, 32'd1, 32'd100001);
        add_report(3, 32'd101002, 32'd201003);
        add_report(3, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_report(3, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();

        // Random phases, each under a new setting; no idling in the last one.
        for (int ph = 1; ph <= NUM_PHASES; ph++)
        begin
            apply_setting(ph);
            idle_on = (ph < NUM_PHASES);
            for (int n = 0; n < PHASE_ITEMS; n++)
                add_random_report();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_records.size() != 0)
            log_error($sformatf("%0d records never returned", expected_records.size()));

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

FILE: task_deadline_jitter_monitor.f
design/tdjm_pkg.sv
design/tdjm_alu.sv
design/tdjm_cfg.sv
design/tdjm_ctrl.sv
design/task_deadline_jitter_monitor.sv
tb/testbench.sv
